// ===== sv/assert_macros.svh =====
// Assertion macros shared by the layout RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define LSL_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("layout assertion failed");

// A condition that must never hold outside reset.
`define LSL_ASSERT_NEVER(label, cond) \
  `LSL_ASSERT(label, !(cond))

`endif

// ===== sv/lsl_pkg.sv =====
// Shared types and constants for the surface layout block.
`default_nettype none

package lsl_pkg;

  // Field widths fixed by the item format.
  localparam int unsigned WANT_W   = 15;
  localparam int unsigned MARGIN_W = 16;
  localparam int unsigned POS_W    = 16;
  localparam int unsigned SIZE_W   = 15;
  localparam int unsigned DIM_W    = 15;
  localparam int unsigned ANCHOR_W = 4;

  // Result field limits.
  localparam int POS_MAX  = 32767;
  localparam int POS_MIN  = -32768;
  localparam int SIZE_MAX = 32767;

  // Anchor bits.
  localparam int unsigned ANC_T_BIT = 0;
  localparam int unsigned ANC_B_BIT = 1;
  localparam int unsigned ANC_L_BIT = 2;
  localparam int unsigned ANC_R_BIT = 3;

  // Anchor sets that reserve space along one edge.
  localparam logic [ANCHOR_W-1:0] ANC_TOP     = 4'b0001;
  localparam logic [ANCHOR_W-1:0] ANC_TOP_LR  = 4'b1101;
  localparam logic [ANCHOR_W-1:0] ANC_BOT     = 4'b0010;
  localparam logic [ANCHOR_W-1:0] ANC_BOT_LR  = 4'b1110;
  localparam logic [ANCHOR_W-1:0] ANC_LEFT    = 4'b0100;
  localparam logic [ANCHOR_W-1:0] ANC_LEFT_TB = 4'b0111;
  localparam logic [ANCHOR_W-1:0] ANC_RIGHT   = 4'b1000;
  localparam logic [ANCHOR_W-1:0] ANC_RIGHT_TB = 4'b1011;

  // Exclusive zone value that lays out against the whole output.
  localparam logic signed [MARGIN_W-1:0] EZ_FULL = -16'sd1;

  // Configuration register indexes.
  typedef enum logic [0:0] {
    CFG_OUTPUT_WIDTH  = 1'b0,
    CFG_OUTPUT_HEIGHT = 1'b1
  } cfg_idx_e;

  // Reset values of the output size.
  localparam logic [DIM_W-1:0] OUT_W_RESET = 15'd1920;
  localparam logic [DIM_W-1:0] OUT_H_RESET = 15'd1080;

  // Placement of one axis.
  typedef struct packed {
    logic signed [POS_W-1:0] pos;
    logic [SIZE_W-1:0]       size;
  } axis_res_t;

endpackage

`default_nettype wire

// ===== sv/lsl_axis.sv =====
// Places a box along one axis inside given bounds and saturates the result.
`default_nettype none

module lsl_axis import lsl_pkg::*; #(
  parameter int unsigned WIDE_BITS = 19
) (
  input  logic signed [WIDE_BITS-1:0] b_pos_i,
  input  logic signed [WIDE_BITS-1:0] b_size_i,
  input  logic [WANT_W-1:0]           want_i,
  input  logic                        anc_lo_i,
  input  logic                        anc_hi_i,
  input  logic signed [MARGIN_W-1:0]  m_lo_i,
  input  logic signed [MARGIN_W-1:0]  m_hi_i,
  output axis_res_t                   res_o
);

  localparam logic signed [WIDE_BITS-1:0] PosHi  = WIDE_BITS'(POS_MAX);
  localparam logic signed [WIDE_BITS-1:0] PosLo  = WIDE_BITS'(POS_MIN);
  localparam logic signed [WIDE_BITS-1:0] SizeHi = WIDE_BITS'(SIZE_MAX);

  logic signed [WIDE_BITS-1:0] m_lo_w;
  logic signed [WIDE_BITS-1:0] m_hi_w;
  logic signed [WIDE_BITS-1:0] want_w;
  logic signed [WIDE_BITS-1:0] half_bound;
  logic signed [WIDE_BITS-1:0] half_want;
  logic signed [WIDE_BITS-1:0] pos_w;
  logic signed [WIDE_BITS-1:0] size_w;

  assign m_lo_w = WIDE_BITS'(m_lo_i);
  assign m_hi_w = WIDE_BITS'(m_hi_i);
  assign want_w = $signed({{(WIDE_BITS-WANT_W){1'b0}}, want_i});

  // Shifting rounds toward minus infinity, so a negative size is biased by one first.
  assign half_bound = (b_size_i + $signed({{(WIDE_BITS-1){1'b0}}, b_size_i[WIDE_BITS-1]})) >>> 1;
  assign half_want  = want_w >>> 1;

  // Stretch, centre, or pin to the single anchored edge.
  always_comb begin
    size_w = want_w;
    if (want_i == '0) begin
      pos_w  = b_pos_i + m_lo_w;
      size_w = b_size_i - (m_lo_w + m_hi_w);
    end else if (anc_lo_i == anc_hi_i) begin
      pos_w = b_pos_i + half_bound - half_want;
    end else if (anc_lo_i) begin
      pos_w = b_pos_i + m_lo_w;
    end else begin
      pos_w = b_pos_i + b_size_i - want_w - m_hi_w;
    end
  end

  // Saturate to the result field ranges.
  always_comb begin
    if (pos_w > PosHi) begin
      res_o.pos = PosHi[POS_W-1:0];
    end else if (pos_w < PosLo) begin
      res_o.pos = PosLo[POS_W-1:0];
    end else begin
      res_o.pos = pos_w[POS_W-1:0];
    end
    if (size_w < 0) begin
      res_o.size = '0;
    end else if (size_w > SizeHi) begin
      res_o.size = SizeHi[SIZE_W-1:0];
    end else begin
      res_o.size = size_w[SIZE_W-1:0];
    end
  end

endmodule

`default_nettype wire

// ===== sv/layer_surface_layout_core.sv =====
// Top level of the layer surface layout block: input stage, layout logic and result register.
//
// Usage:
//   Input channel (in_valid_i / in_ready_o) carries one surface per beat: anchors,
//   desired size, four margins, exclusive zone, mapped flag and a first-item flag that
//   resets the usable area to the full output. The output channel (out_valid_o /
//   out_ready_i) returns one box per input beat, in order.
//   The configuration channel (cfg_valid_i / cfg_ready_o) writes output width
//   (index 0) or height (index 1); it is always ready and should be used only
//   while no surface is in flight.
//   A beat accepted into the input stage moves on to the result register.
//   While the receiver takes each box, the block takes one surface per cycle, set by
//   the single register-to-register pass that also updates the usable area, so a
//   surface sees the area left by the one just before it.
//   When the receiver stalls, the result register holds its beat and the input
//   stage holds one more; after that in_ready_o drops until the output drains.
//   Reset clears both stages, sets the output size to 1920 by 1080 and clears the
//   usable area to zero until the first item arrives.
`default_nettype none
`include "assert_macros.svh"

module layer_surface_layout_core import lsl_pkg::*; #(
  parameter int unsigned COORD_BITS = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // Configuration writes
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [0:0]                 cfg_index_i,
  input  logic [DIM_W-1:0]           cfg_data_i,
  // Surface beats
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic                       first_item_i,
  input  logic [ANCHOR_W-1:0]        anchor_bits_i,
  input  logic [WANT_W-1:0]          want_width_i,
  input  logic [WANT_W-1:0]          want_height_i,
  input  logic signed [MARGIN_W-1:0] margin_top_i,
  input  logic signed [MARGIN_W-1:0] margin_right_i,
  input  logic signed [MARGIN_W-1:0] margin_bottom_i,
  input  logic signed [MARGIN_W-1:0] margin_left_i,
  input  logic signed [MARGIN_W-1:0] exclusive_zone_i,
  input  logic                       is_mapped_i,
  // Box beats
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic signed [POS_W-1:0]    box_x_o,
  output logic signed [POS_W-1:0]    box_y_o,
  output logic [SIZE_W-1:0]          box_width_o,
  output logic [SIZE_W-1:0]          box_height_o
);

  localparam int unsigned BASE_BITS = (COORD_BITS > MARGIN_W) ? COORD_BITS : MARGIN_W;
  localparam int unsigned WIDE_BITS = BASE_BITS + 3;
  localparam logic signed [WIDE_BITS-1:0] CoordHi =
    $signed({{(WIDE_BITS-COORD_BITS+1){1'b0}}, {(COORD_BITS-1){1'b1}}});
  localparam logic signed [WIDE_BITS-1:0] CoordLo = -CoordHi - WIDE_BITS'(1);

  // Saturate a wide value to the usable-area coordinate range.
  function automatic logic signed [COORD_BITS-1:0] coord_sat(
    input logic signed [WIDE_BITS-1:0] v
  );
    logic signed [WIDE_BITS-1:0] c;
    if (v > CoordHi) begin
      c = CoordHi;
    end else if (v < CoordLo) begin
      c = CoordLo;
    end else begin
      c = v;
    end
    return c[COORD_BITS-1:0];
  endfunction

  // Configuration registers.
  logic [DIM_W-1:0] out_w_q, out_h_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_w_q <= OUT_W_RESET;
      out_h_q <= OUT_H_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_OUTPUT_WIDTH:  out_w_q <= cfg_data_i;
        CFG_OUTPUT_HEIGHT: out_h_q <= cfg_data_i;
      endcase
    end
  end

  // Input stage.
  logic                       stg_valid_q;
  logic                       stg_first_q;
  logic [ANCHOR_W-1:0]        stg_anc_q;
  logic [WANT_W-1:0]          stg_ww_q, stg_wh_q;
  logic signed [MARGIN_W-1:0] stg_mt_q, stg_mr_q, stg_mb_q, stg_ml_q, stg_ez_q;
  logic                       stg_mapped_q;
  logic                       stg_adv;
  logic                       out_valid_q;
  logic                       in_fire;

  assign stg_adv    = stg_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !stg_valid_q || stg_adv;
  assign in_fire    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_valid_q <= 1'b0;
    end else if (in_fire) begin
      stg_valid_q <= 1'b1;
    end else if (stg_adv) begin
      stg_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      stg_first_q  <= first_item_i;
      stg_anc_q    <= anchor_bits_i;
      stg_ww_q     <= want_width_i;
      stg_wh_q     <= want_height_i;
      stg_mt_q     <= margin_top_i;
      stg_mr_q     <= margin_right_i;
      stg_mb_q     <= margin_bottom_i;
      stg_ml_q     <= margin_left_i;
      stg_ez_q     <= exclusive_zone_i;
      stg_mapped_q <= is_mapped_i;
    end
  end

  // Usable area state.
  logic signed [COORD_BITS-1:0] usable_x_q, usable_y_q, usable_w_q, usable_h_q;
  logic signed [COORD_BITS-1:0] usable_x_d, usable_y_d, usable_w_d, usable_h_d;
  logic signed [WIDE_BITS-1:0]  out_w_w, out_h_w;
  logic signed [WIDE_BITS-1:0]  cur_x, cur_y, cur_w, cur_h;
  logic signed [WIDE_BITS-1:0]  bnd_x, bnd_y, bnd_w, bnd_h;

  assign out_w_w = $signed({{(WIDE_BITS-DIM_W){1'b0}}, out_w_q});
  assign out_h_w = $signed({{(WIDE_BITS-DIM_W){1'b0}}, out_h_q});

  // A first item restarts from the full output before it is laid out.
  always_comb begin
    if (stg_first_q) begin
      cur_x = '0;
      cur_y = '0;
      cur_w = WIDE_BITS'(coord_sat(out_w_w));
      cur_h = WIDE_BITS'(coord_sat(out_h_w));
    end else begin
      cur_x = WIDE_BITS'(usable_x_q);
      cur_y = WIDE_BITS'(usable_y_q);
      cur_w = WIDE_BITS'(usable_w_q);
      cur_h = WIDE_BITS'(usable_h_q);
    end
  end

  // Bounds: the whole output for a full-output zone, else the usable area.
  always_comb begin
    if (stg_ez_q == EZ_FULL) begin
      bnd_x = '0;
      bnd_y = '0;
      bnd_w = out_w_w;
      bnd_h = out_h_w;
    end else begin
      bnd_x = cur_x;
      bnd_y = cur_y;
      bnd_w = cur_w;
      bnd_h = cur_h;
    end
  end

  // Box placement on both axes.
  axis_res_t res_x, res_y;

  lsl_axis #(
    .WIDE_BITS (WIDE_BITS)
  ) u_axis_x (
    .b_pos_i  (bnd_x),
    .b_size_i (bnd_w),
    .want_i   (stg_ww_q),
    .anc_lo_i (stg_anc_q[ANC_L_BIT]),
    .anc_hi_i (stg_anc_q[ANC_R_BIT]),
    .m_lo_i   (stg_ml_q),
    .m_hi_i   (stg_mr_q),
    .res_o    (res_x)
  );

  lsl_axis #(
    .WIDE_BITS (WIDE_BITS)
  ) u_axis_y (
    .b_pos_i  (bnd_y),
    .b_size_i (bnd_h),
    .want_i   (stg_wh_q),
    .anc_lo_i (stg_anc_q[ANC_T_BIT]),
    .anc_hi_i (stg_anc_q[ANC_B_BIT]),
    .m_lo_i   (stg_mt_q),
    .m_hi_i   (stg_mb_q),
    .res_o    (res_y)
  );

  // Reservation shrinks the usable area from one edge.
  logic                        reserve;
  logic signed [WIDE_BITS-1:0] ez_w;
  logic signed [WIDE_BITS-1:0] new_x, new_y, new_w, new_h;

  assign ez_w    = WIDE_BITS'(stg_ez_q);
  assign reserve = stg_mapped_q && !stg_ez_q[MARGIN_W-1] && (stg_ez_q != '0);

  always_comb begin
    new_x = cur_x;
    new_y = cur_y;
    new_w = cur_w;
    new_h = cur_h;
    unique case (stg_anc_q)
      ANC_TOP, ANC_TOP_LR: begin
        new_y = cur_y + ez_w + WIDE_BITS'(stg_mt_q);
        new_h = cur_h - (ez_w + WIDE_BITS'(stg_mt_q));
      end
      ANC_BOT, ANC_BOT_LR: begin
        new_h = cur_h - (ez_w + WIDE_BITS'(stg_mb_q));
      end
      ANC_LEFT, ANC_LEFT_TB: begin
        new_x = cur_x + ez_w + WIDE_BITS'(stg_ml_q);
        new_w = cur_w - (ez_w + WIDE_BITS'(stg_ml_q));
      end
      ANC_RIGHT, ANC_RIGHT_TB: begin
        new_w = cur_w - (ez_w + WIDE_BITS'(stg_mr_q));
      end
      default: begin
      end
    endcase
    if (new_w < 0) begin
      new_w = '0;
    end
    if (new_h < 0) begin
      new_h = '0;
    end
  end

  // Next usable area when the staged surface moves on.
  always_comb begin
    usable_x_d = usable_x_q;
    usable_y_d = usable_y_q;
    usable_w_d = usable_w_q;
    usable_h_d = usable_h_q;
    if (stg_adv) begin
      if (reserve) begin
        usable_x_d = coord_sat(new_x);
        usable_y_d = coord_sat(new_y);
        usable_w_d = coord_sat(new_w);
        usable_h_d = coord_sat(new_h);
      end else begin
        usable_x_d = cur_x[COORD_BITS-1:0];
        usable_y_d = cur_y[COORD_BITS-1:0];
        usable_w_d = cur_w[COORD_BITS-1:0];
        usable_h_d = cur_h[COORD_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      usable_x_q <= '0;
      usable_y_q <= '0;
      usable_w_q <= '0;
      usable_h_q <= '0;
    end else begin
      usable_x_q <= usable_x_d;
      usable_y_q <= usable_y_d;
      usable_w_q <= usable_w_d;
      usable_h_q <= usable_h_d;
    end
  end

  // Result register.
  logic signed [POS_W-1:0] box_x_q, box_y_q;
  logic [SIZE_W-1:0]       box_w_q, box_h_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (stg_adv) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (stg_adv) begin
      box_x_q <= res_x.pos;
      box_y_q <= res_y.pos;
      box_w_q <= res_x.size;
      box_h_q <= res_y.size;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign box_x_o      = box_x_q;
  assign box_y_o      = box_y_q;
  assign box_width_o  = box_w_q;
  assign box_height_o = box_h_q;

  // Checks on the block's own bookkeeping.
  `LSL_ASSERT_NEVER(a_usable_w_nonneg, usable_w_q[COORD_BITS-1])
  `LSL_ASSERT_NEVER(a_usable_h_nonneg, usable_h_q[COORD_BITS-1])
  `LSL_ASSERT(a_full_blocks_input, (stg_valid_q && out_valid_o && !out_ready_i) |-> !in_ready_o)
  `LSL_ASSERT(a_advance_loads_result, stg_adv |=> out_valid_o)

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
// Self-checking testbench for the layer surface layout core.
`timescale 1ns / 100ps

module tb;
  import lsl_pkg::*;

  localparam int COORD_BITS = 16;
  localparam longint COORD_MAX = (longint'(1) <<< (COORD_BITS - 1)) - 1;
  localparam longint COORD_MIN = -(longint'(1) <<< (COORD_BITS - 1));
  localparam int IDLE_PCT = 14;
  localparam int PHASE_ITEMS = 240;
  localparam int SETTLE_CYCLES = 8;
  localparam int CYCLE_LIMIT = 200000;
  localparam int PRINT_LIMIT = 40;

  // One surface beat and one box beat.
  typedef struct packed {
    logic                       first;
    logic [ANCHOR_W-1:0]        anchors;
    logic [WANT_W-1:0]          want_w;
    logic [WANT_W-1:0]          want_h;
    logic signed [MARGIN_W-1:0] m_top;
    logic signed [MARGIN_W-1:0] m_right;
    logic signed [MARGIN_W-1:0] m_bottom;
    logic signed [MARGIN_W-1:0] m_left;
    logic signed [MARGIN_W-1:0] ez;
    logic                       mapped;
  } surface_t;

  typedef struct packed {
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic [SIZE_W-1:0]       w;
    logic [SIZE_W-1:0]       h;
  } box_t;

  logic                       clk_i = 1'b0;
  logic                       rst_ni = 1'b0;
  logic                       cfg_valid_i = 1'b0;
  logic                       cfg_ready_o;
  logic [0:0]                 cfg_index_i = CFG_OUTPUT_WIDTH;
  logic [DIM_W-1:0]           cfg_data_i = '0;
  logic                       in_valid_i = 1'b0;
  logic                       in_ready_o;
  logic                       first_item_i = 1'b0;
  logic [ANCHOR_W-1:0]        anchor_bits_i = '0;
  logic [WANT_W-1:0]          want_width_i = '0;
  logic [WANT_W-1:0]          want_height_i = '0;
  logic signed [MARGIN_W-1:0] margin_top_i = '0;
  logic signed [MARGIN_W-1:0] margin_right_i = '0;
  logic signed [MARGIN_W-1:0] margin_bottom_i = '0;
  logic signed [MARGIN_W-1:0] margin_left_i = '0;
  logic signed [MARGIN_W-1:0] exclusive_zone_i = '0;
  logic                       is_mapped_i = 1'b0;
  logic                       out_valid_o;
  logic                       out_ready_i = 1'b0;
  logic signed [POS_W-1:0]    box_x_o;
  logic signed [POS_W-1:0]    box_y_o;
  logic [SIZE_W-1:0]          box_width_o;
  logic [SIZE_W-1:0]          box_height_o;

  layer_surface_layout_core #(.COORD_BITS(COORD_BITS)) u_top (
    .clk_i, .rst_ni,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_ready_o, .first_item_i, .anchor_bits_i,
    .want_width_i, .want_height_i,
    .margin_top_i, .margin_right_i, .margin_bottom_i, .margin_left_i,
    .exclusive_zone_i, .is_mapped_i,
    .out_valid_o, .out_ready_i, .box_x_o, .box_y_o, .box_width_o, .box_height_o
  );

  // Predictor copy of the configuration and of the usable area.
  logic [DIM_W-1:0]             out_w_cfg = OUT_W_RESET;
  logic [DIM_W-1:0]             out_h_cfg = OUT_H_RESET;
  logic signed [COORD_BITS-1:0] area_x = '0;
  logic signed [COORD_BITS-1:0] area_y = '0;
  logic signed [COORD_BITS-1:0] area_w = '0;
  logic signed [COORD_BITS-1:0] area_h = '0;

  surface_t pending_surfaces[$];
  box_t     expected_boxes[$];
  int       surfaces_queued = 0;
  int       boxes_seen = 0;
  int       mismatches = 0;
  logic     in_beat = 1'b0;
  bit       steady = 1'b0;

  logic [ANCHOR_W-1:0] reserve_sets[8] = '{ANC_TOP, ANC_TOP_LR, ANC_BOT, ANC_BOT_LR,
                                           ANC_LEFT, ANC_LEFT_TB, ANC_RIGHT, ANC_RIGHT_TB};

  // Clock with a 10 ns period.
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic longint clip(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // Position and size along one axis of the bounds.
  function automatic void place_span(input longint base, input longint span,
                                     input longint want, input bit lo, input bit hi,
                                     input longint m_lo, input longint m_hi,
                                     output longint pos, output longint size);
    size = want;
    if (want == 0) begin
      pos = base + m_lo;
      size = span - (m_lo + m_hi);
    end else if (lo == hi) begin
      pos = base + span / 2 - want / 2;
    end else if (lo) begin
      pos = base + m_lo;
    end else begin
      pos = base + span - want - m_hi;
    end
    if (size < 0) size = 0;
  endfunction

  // Box of one surface, updating the usable area as the block does.
  function automatic box_t place_surface(surface_t s);
    longint bx, by, bw, bh, px, py, sw, sh, x, y, w, h, ez;
    box_t   b;
    ez = s.ez;
    if (s.first) begin
      area_x = '0;
      area_y = '0;
      area_w = COORD_BITS'(clip(out_w_cfg, COORD_MIN, COORD_MAX));
      area_h = COORD_BITS'(clip(out_h_cfg, COORD_MIN, COORD_MAX));
    end
    // The full-output zone ignores whatever space is already reserved.
    if (s.ez == EZ_FULL) begin
      bx = 0;
      by = 0;
      bw = out_w_cfg;
      bh = out_h_cfg;
    end else begin
      bx = area_x;
      by = area_y;
      bw = area_w;
      bh = area_h;
    end
    place_span(bx, bw, s.want_w, s.anchors[ANC_L_BIT], s.anchors[ANC_R_BIT],
               s.m_left, s.m_right, px, sw);
    place_span(by, bh, s.want_h, s.anchors[ANC_T_BIT], s.anchors[ANC_B_BIT],
               s.m_top, s.m_bottom, py, sh);
    // A mapped surface on one edge with a positive zone shrinks the area.
    if (ez > 0 && s.mapped) begin
      x = area_x;
      y = area_y;
      w = area_w;
      h = area_h;
      case (s.anchors)
        ANC_TOP, ANC_TOP_LR: begin
          y = y + ez + s.m_top;
          h = h - (ez + s.m_top);
        end
        ANC_BOT, ANC_BOT_LR: begin
          h = h - (ez + s.m_bottom);
        end
        ANC_LEFT, ANC_LEFT_TB: begin
          x = x + ez + s.m_left;
          w = w - (ez + s.m_left);
        end
        ANC_RIGHT, ANC_RIGHT_TB: begin
          w = w - (ez + s.m_right);
        end
        default: ;
      endcase
      if (w < 0) w = 0;
      if (h < 0) h = 0;
      area_x = COORD_BITS'(clip(x, COORD_MIN, COORD_MAX));
      area_y = COORD_BITS'(clip(y, COORD_MIN, COORD_MAX));
      area_w = COORD_BITS'(clip(w, COORD_MIN, COORD_MAX));
      area_h = COORD_BITS'(clip(h, COORD_MIN, COORD_MAX));
    end
    b.x = POS_W'(clip(px, POS_MIN, POS_MAX));
    b.y = POS_W'(clip(py, POS_MIN, POS_MAX));
    b.w = SIZE_W'(clip(sw, 0, SIZE_MAX));
    b.h = SIZE_W'(clip(sh, 0, SIZE_MAX));
    return b;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    mismatches++;
    if (mismatches <= PRINT_LIMIT)
      $display("mismatch on %s: got %0d, expected %0d (box %0d)", what, got, want,
               boxes_seen);
  endtask

  // Driver: offers queued surfaces and paces the box receiver.
  always @(negedge clk_i) begin : drive_surfaces
    surface_t cur;
    if (rst_ni && (!in_valid_i || in_beat)) begin
      if (pending_surfaces.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
        cur = pending_surfaces.pop_front();
        in_valid_i       <= 1'b1;
        first_item_i     <= cur.first;
        anchor_bits_i    <= cur.anchors;
        want_width_i     <= cur.want_w;
        want_height_i    <= cur.want_h;
        margin_top_i     <= cur.m_top;
        margin_right_i   <= cur.m_right;
        margin_bottom_i  <= cur.m_bottom;
        margin_left_i    <= cur.m_left;
        exclusive_zone_i <= cur.ez;
        is_mapped_i      <= cur.mapped;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
    if (rst_ni) out_ready_i <= steady || ($urandom_range(99) >= IDLE_PCT);
  end

  // Monitor: predicts on each accepted surface and checks each box beat.
  always @(posedge clk_i or negedge rst_ni) begin : watch_ports
    surface_t s;
    box_t     want_box;
    if (!rst_ni) begin
      in_beat <= 1'b0;
    end else begin
      in_beat <= in_valid_i && in_ready_o;
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == CFG_OUTPUT_WIDTH) out_w_cfg = cfg_data_i;
        else out_h_cfg = cfg_data_i;
      end
      if (in_valid_i && in_ready_o) begin
        s = '{first_item_i, anchor_bits_i, want_width_i, want_height_i, margin_top_i,
              margin_right_i, margin_bottom_i, margin_left_i, exclusive_zone_i,
              is_mapped_i};
        expected_boxes.push_back(place_surface(s));
      end
      if (out_valid_o && out_ready_i) begin
        boxes_seen <= boxes_seen + 1;
        if (expected_boxes.size() == 0) begin
          report_mismatch("unexpected box beat", box_x_o, 0);
        end else begin
          want_box = expected_boxes.pop_front();
          if (box_x_o !== want_box.x) report_mismatch("box_x", box_x_o, want_box.x);
          if (box_y_o !== want_box.y) report_mismatch("box_y", box_y_o, want_box.y);
          if (box_width_o !== want_box.w)
            report_mismatch("box_width", box_width_o, want_box.w);
          if (box_height_o !== want_box.h)
            report_mismatch("box_height", box_height_o, want_box.h);
        end
      end
    end
  end

  function automatic surface_t surface(int first, logic [ANCHOR_W-1:0] anc, int ww, int wh,
                                       int mt, int mr, int mb, int ml, int ez, int mapped);
    surface_t s;
    s = '{first[0], anc, ww[WANT_W-1:0], wh[WANT_W-1:0], mt[MARGIN_W-1:0],
          mr[MARGIN_W-1:0], mb[MARGIN_W-1:0], ml[MARGIN_W-1:0], ez[MARGIN_W-1:0],
          mapped[0]};
    return s;
  endfunction

  function automatic logic [WANT_W-1:0] pick_want();
    int r;
    r = $urandom_range(19);
    if (r < 7) return '0;
    if (r < 16) return WANT_W'($urandom_range(1, 2000));
    return WANT_W'($urandom_range(32767));
  endfunction

  function automatic logic signed [MARGIN_W-1:0] pick_margin();
    int r;
    r = $urandom_range(19);
    if (r < 10) return MARGIN_W'($urandom_range(40));
    if (r < 14) return MARGIN_W'($signed($urandom_range(80)) - 40);
    if (r < 17) return '0;
    return MARGIN_W'($urandom);
  endfunction

  function automatic surface_t random_surface(bit first);
    surface_t s;
    s.first = first;
    if ($urandom_range(99) < 60) s.anchors = reserve_sets[$urandom_range(7)];
    else s.anchors = ANCHOR_W'($urandom_range(15));
    s.want_w   = pick_want();
    s.want_h   = pick_want();
    s.m_top    = pick_margin();
    s.m_right  = pick_margin();
    s.m_bottom = pick_margin();
    s.m_left   = pick_margin();
    case ($urandom_range(4))
      0:       s.ez = EZ_FULL;
      1:       s.ez = '0;
      2, 3:    s.ez = MARGIN_W'($urandom_range(1, 300));
      default: s.ez = MARGIN_W'($urandom);
    endcase
    s.mapped = ($urandom_range(99) < 85);
    return s;
  endfunction

  task automatic queue_surface(surface_t s);
    pending_surfaces.push_back(s);
    surfaces_queued++;
  endtask

  // Mostly whole layout passes that open with a first item; some stray flags.
  task automatic queue_layouts(int count);
    int n, len;
    n = 0;
    while (n < count) begin
      len = $urandom_range(1, 8);
      for (int k = 0; k < len; k++) begin
        queue_surface(random_surface(k == 0 ? ($urandom_range(9) != 0)
                                            : ($urandom_range(19) == 0)));
        n++;
      end
    end
  endtask

  // Wait until every queued surface has come back as a box.
  task automatic drain_boxes();
    while (boxes_seen != surfaces_queued) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, int value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value[DIM_W-1:0];
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  // Watchdog on the whole run.
  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("tb failed");
    $finish;
  end

  // Main sequence: reset, directed surfaces, then random phases per output size.
  initial begin : run_phases
    int phase_w[7] = '{32767, 0, 800, 0, 1, 32767, 1920};
    int phase_h[7] = '{32767, 0, 600, 0, 32767, 1, 1080};
    int w, h;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Before any first item the usable area is empty.
    queue_surface(surface(0, ANC_TOP, 100, 30, 0, 0, 0, 0, 0, 1));
    queue_surface(surface(0, 4'b0000, 0, 0, 10, 10, 10, 10, -1, 1));
    // Reservation along each edge, then sets that must not reserve.
    queue_surface(surface(1, ANC_TOP_LR, 0, 30, 5, 0, 0, 0, 30, 1));
    queue_surface(surface(0, ANC_BOT_LR, 0, 40, 0, 0, 2, 0, 40, 1));
    queue_surface(surface(0, ANC_LEFT, 60, 0, 0, 0, 0, 3, 50, 1));
    queue_surface(surface(0, ANC_RIGHT_TB, 70, 0, 0, -5, 0, 0, 60, 1));
    queue_surface(surface(0, ANC_TOP, 0, 20, 4, 0, 0, 0, 20, 0));
    queue_surface(surface(0, 4'b1111, 0, 0, 1, 2, 3, 4, 100, 1));
    queue_surface(surface(0, 4'b0000, 500, 300, 0, 0, 0, 0, 0, 1));
    queue_surface(surface(0, ANC_BOT, 200, 50, 0, 0, 7, 0, 0, 1));
    queue_surface(surface(0, ANC_RIGHT, 100, 100, 0, 9, 0, 0, 0, 1));
    queue_surface(surface(0, ANC_LEFT_TB, 0, 0, 0, 0, 0, 0, 0, 1));
    // A stretch that goes below zero, and the field extremes.
    queue_surface(surface(0, 4'b0000, 0, 0, 20000, 20000, 20000, 20000, 0, 1));
    queue_surface(surface(0, 4'b0000, 32767, 32767, 0, 0, 0, 0, 0, 1));
    queue_surface(surface(0, 4'b0000, 0, 0, -32768, -32768, -32768, -32768, -1, 1));
    queue_surface(surface(0, 4'b0101, 1, 1, 32767, 32767, 32767, 32767, 0, 1));
    // Overflow of the usable area in both directions.
    queue_surface(surface(0, ANC_LEFT, 10, 10, 0, 0, 0, 32767, 32767, 1));
    queue_surface(surface(0, ANC_TOP, 5, 5, 0, 0, 0, 0, -32768, 1));
    queue_surface(surface(1, ANC_TOP, 0, 0, -32768, 0, 0, 0, 32767, 1));
    queue_surface(surface(0, ANC_BOT, 0, 0, 0, 0, 32767, 0, 32767, 1));
    queue_surface(surface(1, ANC_RIGHT, 0, 0, 0, -32768, 0, 0, 1, 1));
    queue_surface(surface(0, ANC_RIGHT, 0, 0, 0, 0, 0, 0, 1, 1));
    queue_surface(surface(1, 4'b1111, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 0));
    drain_boxes();

    for (int p = 0; p < 7; p++) begin
      w = phase_w[p];
      h = phase_h[p];
      if (p == 3) begin
        w = $urandom_range(32767);
        h = $urandom_range(32767);
      end
      write_reg(CFG_OUTPUT_WIDTH, w);
      write_reg(CFG_OUTPUT_HEIGHT, h);
      @(negedge clk_i);
      cfg_valid_i <= 1'b0;
      @(posedge clk_i);
      steady = (p == 2);
      // The sender holds off halfway until every box is back.
      queue_layouts(PHASE_ITEMS / 2);
      drain_boxes();
      queue_layouts(PHASE_ITEMS / 2);
      drain_boxes();
    end

    if (expected_boxes.size() != 0)
      report_mismatch("boxes never produced", 0, expected_boxes.size());
    if (mismatches == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

// ===== layer_surface_layout_core.f =====
+incdir+sv
sv/lsl_pkg.sv
sv/lsl_axis.sv
sv/layer_surface_layout_core.sv
bench/tb.sv
